@@ src/lpr_pkg.sv @@
// Package for the LRU page replacement block: beat structs, action codes, defaults.
// Used by lpr_cell and lru_page_replacement; depends on nothing else.
package lpr_pkg;

    // Default sizes of the resident set and of a stored page number.
    localparam int FRAMES_DEF    = 16;
    localparam int PAGE_BITS_DEF = 16;

    // Register reset value and counter limit.
    localparam logic [4:0]  LIMIT_RESET = 5'd16;
    localparam logic [15:0] FAULT_MAX   = 16'hFFFF;

    // Action codes carried by a result beat.
    localparam logic [1:0] ACT_HIT     = 2'd0;
    localparam logic [1:0] ACT_LOAD    = 2'd1;
    localparam logic [1:0] ACT_REPLACE = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_UPD
    } state_t;

    typedef struct packed {
        logic [15:0] page_number;
        logic        start_of_run;
    } req_beat_t;

    typedef struct packed {
        logic        was_hit;
        logic [1:0]  action;
        logic [3:0]  frame_index;
        logic [15:0] evicted_page;
        logic [15:0] fault_total;
    } rsp_beat_t;

    // Update command broadcast to every cell.
    typedef struct packed {
        logic en;
        logic hit;
        logic load;
    } upd_ctl_t;

endpackage

@@ src/lpr_cell.sv @@
// One frame of the resident set: stored page, recency rank and match flag.
// Depends on lpr_pkg; instantiated in a row by lru_page_replacement.
module lpr_cell #(
    parameter int FRAMES     = lpr_pkg::FRAMES_DEF,
    parameter int PAGE_BITS  = lpr_pkg::PAGE_BITS_DEF,
    parameter int CELL_INDEX = 0,
    localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1,
    localparam int FW = $clog2(FRAMES + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cap,
    input  logic                  clear,
    input  logic [PAGE_BITS-1:0]  cmp_page,
    input  logic [FW-1:0]         filled,
    input  lpr_pkg::upd_ctl_t     ctl,
    input  logic [FW-1:0]         thresh,
    input  logic                  hit_in,
    input  logic [IW-1:0]         hit_idx_in,
    input  logic [IW-1:0]         hit_rank_in,
    input  logic [IW-1:0]         vic_idx_in,
    input  logic [PAGE_BITS-1:0]  vic_page_in,
    output logic                  hit_out,
    output logic [IW-1:0]         hit_idx_out,
    output logic [IW-1:0]         hit_rank_out,
    output logic [IW-1:0]         vic_idx_out,
    output logic [PAGE_BITS-1:0]  vic_page_out
);

    localparam logic [FW-1:0] MY_FW = FW'(CELL_INDEX);
    localparam logic [IW-1:0] MY_IW = IW'(CELL_INDEX);

    logic [PAGE_BITS-1:0] page_reg;
    logic [IW-1:0]        rank_reg;
    logic                 match_reg;

    logic                 filled_here;
    logic                 victim;
    logic                 sel;
    logic [FW-1:0]        rank_ext;

    // A frame counts as filled only while it lies below the fill count; a load picks the first free frame.
    always_comb
    begin
        filled_here = (MY_FW < filled);
        rank_ext    = FW'(rank_reg);
        victim      = filled_here && (rank_ext == filled - FW'(1));
        if (ctl.hit)
        begin
            sel = match_reg;
        end
        else if (ctl.load)
        begin
            sel = (MY_FW == filled);
        end
        else
        begin
            sel = victim;
        end
    end

    // Pass the hit and victim reports down the row; at most one cell adds to each.
    always_comb
    begin
        hit_out      = hit_in | match_reg;
        hit_idx_out  = hit_idx_in | (match_reg ? MY_IW : '0);
        hit_rank_out = hit_rank_in | (match_reg ? rank_reg : '0);
        vic_idx_out  = vic_idx_in | (victim ? MY_IW : '0);
        vic_page_out = vic_page_in | (victim ? page_reg : '0);
    end

    // Compare against the incoming page on the accepting edge.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else if (cap)
        begin
            match_reg <= !clear && filled_here && (page_reg == cmp_page);
        end
    end

    // Recency update: the chosen frame becomes newest, younger frames age by one.
    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            if (sel)
            begin
                rank_reg <= '0;
            end
            else if (filled_here && (rank_ext < thresh))
            begin
                rank_reg <= rank_reg + IW'(1);
            end
            if (sel && !ctl.hit)
            begin
                page_reg <= cmp_page;
            end
        end
    end

endmodule

@@ src/lru_page_replacement.sv @@
// LRU page replacement block: input registers, control sequencer and a row of frame cells.
// Depends on lpr_pkg and lpr_cell.
//
// Usage: each beat on the req channel (req_valid/req_ready, payload req) is one page
// access. Each access gives exactly one beat on the rsp channel (rsp_valid/rsp_ready,
// payload rsp) with hit flag, action, frame, evicted page and the fault count.
// The cfg channel (cfg_valid/cfg_ready, cfg_data) writes the resident frame limit;
// write it only while no access is in flight.
// In ST_IDLE an accepted page is compared against every frame cell; in ST_UPD the ranks
// of all cells are updated from the single hit or victim report that ripples down the
// row, and the result is registered. A new access is accepted only once the previous
// one has made its update.
// When the receiver stalls, one finished result waits in the output register while the
// next access is accepted and compared; its update waits until the register drains.
// Reset empties the resident set (fill count and fault count zero) and sets the limit to
// sixteen. Frame storage itself is not cleared, so the block is ready at once.
module lru_page_replacement #(
    parameter int FRAMES    = lpr_pkg::FRAMES_DEF,
    parameter int PAGE_BITS = lpr_pkg::PAGE_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  lpr_pkg::req_beat_t req,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output lpr_pkg::rsp_beat_t rsp,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [4:0]         cfg_data
);

    localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int FW = $clog2(FRAMES + 1);

    lpr_pkg::state_t     state_reg, state_next;
    logic [PAGE_BITS-1:0] page_reg;
    logic [FW-1:0]        filled_reg;
    logic [15:0]          fault_reg;
    logic [4:0]           limit_reg;
    logic                 rsp_valid_reg;
    lpr_pkg::rsp_beat_t   rsp_reg;

    logic                 accept;
    logic                 do_upd;
    logic [31:0]          page_in_ext;
    logic [PAGE_BITS-1:0] page_in;
    logic [7:0]           lim8;
    logic                 hit;
    logic                 load;
    lpr_pkg::upd_ctl_t    ctl;
    logic [FW-1:0]        thresh;
    logic [31:0]          idx_ext;
    logic [31:0]          evict_ext;
    lpr_pkg::rsp_beat_t   rsp_next;

    logic                 hit_c      [0:FRAMES];
    logic [IW-1:0]        hit_idx_c  [0:FRAMES];
    logic [IW-1:0]        hit_rank_c [0:FRAMES];
    logic [IW-1:0]        vic_idx_c  [0:FRAMES];
    logic [PAGE_BITS-1:0] vic_page_c [0:FRAMES];

    // Handshakes.
    assign req_ready = (state_reg == lpr_pkg::ST_IDLE);
    assign accept    = req_valid && req_ready;
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Keep only the low PAGE_BITS bits of the incoming page.
    assign page_in_ext = 32'(req.page_number);
    assign page_in     = page_in_ext[PAGE_BITS-1:0];

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lpr_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = lpr_pkg::ST_UPD;
                end
            end
            lpr_pkg::ST_UPD:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    state_next = lpr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lpr_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs: the update runs once the output register is free.
    always_comb
    begin
        do_upd = 1'b0;
        unique case (state_reg)
            lpr_pkg::ST_IDLE: do_upd = 1'b0;
            lpr_pkg::ST_UPD:  do_upd = !rsp_valid_reg || rsp_ready;
            default:          do_upd = 1'b0;
        endcase
    end

    // Effective limit, clamped to one through FRAMES.
    always_comb
    begin
        lim8 = 8'(limit_reg);
        if (lim8 == 8'd0)
        begin
            lim8 = 8'd1;
        end
        if (lim8 > 8'(FRAMES))
        begin
            lim8 = 8'(FRAMES);
        end
    end

    // Decide hit, load or replace and the aging threshold for the cells.
    always_comb
    begin
        hit      = hit_c[FRAMES];
        load     = !hit && (8'(filled_reg) < lim8);
        ctl.en   = do_upd;
        ctl.hit  = hit;
        ctl.load = load;
        if (hit)
        begin
            thresh = FW'(hit_rank_c[FRAMES]);
        end
        else if (load)
        begin
            thresh = filled_reg;
        end
        else
        begin
            thresh = filled_reg - FW'(1);
        end
    end

    // Result beat.
    always_comb
    begin
        if (hit)
        begin
            idx_ext = 32'(hit_idx_c[FRAMES]);
        end
        else if (load)
        begin
            idx_ext = 32'(filled_reg);
        end
        else
        begin
            idx_ext = 32'(vic_idx_c[FRAMES]);
        end
        evict_ext = 32'(vic_page_c[FRAMES]);

        rsp_next.was_hit      = hit;
        rsp_next.frame_index  = idx_ext[3:0];
        rsp_next.evicted_page = '0;
        rsp_next.fault_total  = fault_reg;
        if (hit)
        begin
            rsp_next.action = lpr_pkg::ACT_HIT;
        end
        else
        begin
            if (fault_reg != lpr_pkg::FAULT_MAX)
            begin
                rsp_next.fault_total = fault_reg + 16'd1;
            end
            if (load)
            begin
                rsp_next.action = lpr_pkg::ACT_LOAD;
            end
            else
            begin
                rsp_next.action       = lpr_pkg::ACT_REPLACE;
                rsp_next.evicted_page = evict_ext[15:0];
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lpr_pkg::ST_IDLE;
            filled_reg    <= '0;
            fault_reg     <= '0;
            limit_reg     <= lpr_pkg::LIMIT_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                limit_reg <= cfg_data;
            end
            if (accept && req.start_of_run)
            begin
                filled_reg <= '0;
                fault_reg  <= '0;
            end
            else if (do_upd)
            begin
                fault_reg <= rsp_next.fault_total;
                if (load)
                begin
                    filled_reg <= filled_reg + FW'(1);
                end
            end
            if (do_upd)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            page_reg <= page_in;
        end
        if (do_upd)
        begin
            rsp_reg <= rsp_next;
        end
    end

    // Row of frame cells; the hit and victim reports ripple from cell zero upward.
    assign hit_c[0]      = 1'b0;
    assign hit_idx_c[0]  = '0;
    assign hit_rank_c[0] = '0;
    assign vic_idx_c[0]  = '0;
    assign vic_page_c[0] = '0;

    generate
        for (genvar g = 0; g < FRAMES; g++)
        begin : g_cell
            lpr_cell #(
                .FRAMES     (FRAMES),
                .PAGE_BITS  (PAGE_BITS),
                .CELL_INDEX (g)
            ) u_cell (
                .clk          (clk),
                .rst_n        (rst_n),
                .cap          (accept),
                .clear        (req.start_of_run),
                .cmp_page     (accept ? page_in : page_reg),
                .filled       (filled_reg),
                .ctl          (ctl),
                .thresh       (thresh),
                .hit_in       (hit_c[g]),
                .hit_idx_in   (hit_idx_c[g]),
                .hit_rank_in  (hit_rank_c[g]),
                .vic_idx_in   (vic_idx_c[g]),
                .vic_page_in  (vic_page_c[g]),
                .hit_out      (hit_c[g+1]),
                .hit_idx_out  (hit_idx_c[g+1]),
                .hit_rank_out (hit_rank_c[g+1]),
                .vic_idx_out  (vic_idx_c[g+1]),
                .vic_page_out (vic_page_c[g+1])
            );
        end
    endgenerate

endmodule

@@ tb/lpr_tb_pkg.sv @@
// Scoreboard for the LRU page replacement testbench: tracks the resident set and checks results.
// Depends on lpr_pkg for the beat structs, action codes and register defaults.
`timescale 1ns / 1ps

package lpr_tb_pkg;

    import lpr_pkg::*;

    class lru_tracker;

        // Shadow copy of the resident set and the counters.
        logic [15:0] page_of [FRAMES_DEF];
        logic [3:0]  rank_of [FRAMES_DEF];
        logic [4:0]  filled;
        logic [15:0] faults;
        logic [4:0]  frame_limit;

        // Results still owed by the block, oldest first.
        rsp_beat_t   owed_results [$];
        int unsigned mismatches;

        function new();
            filled      = '0;
            faults      = '0;
            frame_limit = LIMIT_RESET;
            mismatches  = 0;
        endfunction

        function void write_limit(logic [4:0] value);
            frame_limit = value;
        endfunction

        function int unsigned pending();
            return owed_results.size();
        endfunction

        // Make frame f the most recent; every frame younger than it ages by one.
        function void make_newest(int f);
            logic [3:0] old_rank;
            old_rank = rank_of[f];
            for (int i = 0; i < int'(filled); i++)
            begin
                if (rank_of[i] < old_rank)
                    rank_of[i] = rank_of[i] + 4'd1;
            end
            rank_of[f] = '0;
        endfunction

        // Work out the result of one accepted access and queue it.
        function void note_access(req_beat_t access);
            rsp_beat_t outcome;
            int        hit_at;
            int        usable;
            int        victim;
            outcome = '0;
            hit_at  = -1;
            if (access.start_of_run)
            begin
                filled = '0;
                faults = '0;
            end
            for (int i = 0; i < int'(filled); i++)
            begin
                if (hit_at < 0 && page_of[i] == access.page_number)
                    hit_at = i;
            end
            if (hit_at >= 0)
            begin
                outcome.was_hit     = 1'b1;
                outcome.action      = ACT_HIT;
                outcome.frame_index = 4'(hit_at);
                make_newest(hit_at);
            end
            else
            begin
                if (faults != FAULT_MAX)
                    faults = faults + 16'd1;
                // A limit of zero acts as one, and anything past the array as the array.
                usable = int'(frame_limit);
                if (usable < 1)
                    usable = 1;
                if (usable > FRAMES_DEF)
                    usable = FRAMES_DEF;
                if (int'(filled) < usable)
                begin
                    outcome.action      = ACT_LOAD;
                    outcome.frame_index = 4'(filled);
                    for (int i = 0; i < int'(filled); i++)
                        rank_of[i] = rank_of[i] + 4'd1;
                    page_of[filled] = access.page_number;
                    rank_of[filled] = '0;
                    filled = filled + 5'd1;
                end
                else
                begin
                    // Victim is the oldest among all filled frames, lowest index on a tie.
                    victim = 0;
                    for (int i = 1; i < int'(filled); i++)
                    begin
                        if (rank_of[i] > rank_of[victim])
                            victim = i;
                    end
                    outcome.action       = ACT_REPLACE;
                    outcome.frame_index  = 4'(victim);
                    outcome.evicted_page = page_of[victim];
                    page_of[victim]      = access.page_number;
                    make_newest(victim);
                end
            end
            outcome.fault_total = faults;
            owed_results.insert(owed_results.size(), outcome);
        endfunction

        function void compare_field(string field, logic [15:0] want, logic [15:0] got);
            if (want !== got)
            begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
                mismatches++;
            end
        endfunction

        // Compare one accepted result beat with the oldest owed result.
        function void check_result(rsp_beat_t got);
            rsp_beat_t want;
            if (owed_results.size() == 0)
            begin
                $display("%0t: unexpected result beat, expected none, actual %0h", $time, got);
                mismatches++;
                return;
            end
            want = owed_results.pop_front();
            compare_field("was_hit", 16'(want.was_hit), 16'(got.was_hit));
            compare_field("action", 16'(want.action), 16'(got.action));
            compare_field("frame_index", 16'(want.frame_index), 16'(got.frame_index));
            compare_field("evicted_page", want.evicted_page, got.evicted_page);
            compare_field("fault_total", want.fault_total, got.fault_total);
        endfunction

    endclass

endpackage

@@ tb/tb_top.sv @@
// Top of the LRU page replacement testbench: clock, reset, drivers, receiver and watchdog.
// Depends on lpr_pkg, lpr_tb_pkg and the lru_page_replacement block.
`timescale 1ns / 1ps

module tb_top;

    import lpr_pkg::*;
    import lpr_tb_pkg::*;

    localparam int STALL_LIMIT = 1000;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 60;
    localparam int POOL_SIZE   = 20;

    logic       clk;
    logic       rst_n;
    logic       req_valid;
    logic       req_ready;
    req_beat_t  req;
    logic       rsp_valid;
    logic       rsp_ready = 1'b0;
    rsp_beat_t  rsp;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [4:0] cfg_data;

    lru_tracker tracker;
    bit         no_idle;
    int         idle_cycles;
    int         rsp_wait;
    logic [4:0] limit_now;

    lru_page_replacement dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Free-running clock, 2 ns period.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int draw_gap();
        if (no_idle)
            return 0;
        return $urandom_range(0, 19);
    endfunction

    // Receiver: after each result beat, stall for a freshly drawn number of cycles.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
            rsp_wait  <= draw_gap();
        end
        else if (rsp_valid && rsp_ready)
        begin
            int gap;
            gap = draw_gap();
            if (gap == 0)
                rsp_ready <= 1'b1;
            else
            begin
                rsp_ready <= 1'b0;
                rsp_wait  <= gap;
            end
        end
        else if (!rsp_ready)
        begin
            if (rsp_wait <= 1)
                rsp_ready <= 1'b1;
            else
                rsp_wait <= rsp_wait - 1;
        end
    end

    // Result checking and the watchdog on cycles without any accepted beat.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            idle_cycles <= 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
                tracker.check_result(rsp);
            if ((rsp_valid && rsp_ready) || (req_valid && req_ready) ||
                (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else if (idle_cycles + 1 >= STALL_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Offer one access beat after a random gap and predict it once accepted.
    task automatic send_access(logic [15:0] page, logic start);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.page_number  <= page;
        req.start_of_run <= start;
        req_valid        <= 1'b1;
        do
            @(posedge clk);
        while (!(req_valid && req_ready));
        tracker.note_access('{page_number: page, start_of_run: start});
    endtask

    // Stop offering beats and wait until every owed result has come back.
    task automatic drain();
        req_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write the frame limit register; only called with the block idle.
    task automatic write_limit_reg(logic [4:0] value);
        drain();
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        tracker.write_limit(value);
        limit_now = value;
    endtask

    initial
    begin
        logic [15:0] pool [POOL_SIZE];
        logic [4:0]  phase_limits [PHASES];
        int          usable;
        int          span;
        logic [15:0] page;
        logic        start;

        tracker     = new();
        no_idle     = 1'b0;
        limit_now   = LIMIT_RESET;
        rst_n       <= 1'b0;
        req_valid   <= 1'b0;
        req         <= '0;
        cfg_valid   <= 1'b0;
        cfg_data    <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extreme pages, hits, loads into free frames.
        send_access(16'h0000, 1'b1);
        send_access(16'hFFFF, 1'b0);
        send_access(16'h0000, 1'b0);
        send_access(16'hFFFF, 1'b0);
        send_access(16'h8000, 1'b0);
        send_access(16'h0001, 1'b0);

        // Limit lowered below the fill count: old frames stay and misses replace.
        write_limit_reg(5'd2);
        send_access(16'h1234, 1'b0);
        send_access(16'h0000, 1'b0);
        send_access(16'h5555, 1'b0);
        send_access(16'hAAAA, 1'b0);

        // A limit of zero behaves as a single frame.
        write_limit_reg(5'd0);
        send_access(16'h00FF, 1'b1);
        send_access(16'hFF00, 1'b0);
        send_access(16'hFF00, 1'b0);
        send_access(16'h00FF, 1'b0);

        // A limit past the array: fill all frames, then one more forces a replace.
        write_limit_reg(5'd31);
        for (int i = 0; i <= FRAMES_DEF; i++)
            send_access(16'(i * 16'h1001), i == 0);

        // Single frame with no idling: back-to-back misses keep replacing the one frame.
        write_limit_reg(5'd1);
        no_idle = 1'b1;
        for (int n = 0; n < 16; n++)
            send_access(16'(n), n == 0);
        no_idle = 1'b0;
        send_access(16'h000F, 1'b0);
        send_access(16'h7777, 1'b0);
        send_access(16'h7777, 1'b1);

        // Random phases over a spread of limits, the extremes among them.
        phase_limits = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd17, 5'd2, 5'd8, 5'd4, 5'd15, 5'd16};
        phase_limits[PHASES - 1] = 5'($urandom_range(0, 31));
        for (int p = 0; p < PHASES; p++)
        begin
            write_limit_reg(phase_limits[p]);
            no_idle = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < POOL_SIZE; k++)
                pool[k] = 16'($urandom);
            usable = int'(limit_now);
            if (usable < 1)
                usable = 1;
            if (usable > FRAMES_DEF)
                usable = FRAMES_DEF;
            span = usable + $urandom_range(0, 4);
            if (span > POOL_SIZE)
                span = POOL_SIZE;
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                // Mostly a working set as large as the limit or a little larger, some noise.
                if ($urandom_range(0, 9) == 0)
                    page = 16'($urandom);
                else
                    page = pool[$urandom_range(0, span - 1)];
                start = ($urandom_range(0, 49) == 0) || (k == 0 && $urandom_range(0, 1) == 0);
                send_access(page, start);
            end
        end

        drain();
        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
